@@ rtl/core/nrt_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nrt_pkg
// Shared types and constants for the NACK retry table: the entry record held
// by each cell, the per-cycle chain command and the field codes.
// ============================================================================
package nrt_pkg;

    // Sizing
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int RESULT_CAP      = 32;
    localparam int SEQ_W           = 16;
    localparam int TRIES_W         = 4;
    localparam int TIME_W          = 32;
    localparam int CNT_W           = 32;
    localparam int INTV_W          = 16;
    localparam int KIND_W          = 2;
    localparam int OPC_W           = 2;
    localparam int RCNT_W          = $clog2(RESULT_CAP + 1);
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int S_DATA_W        = SEQ_W + TIME_W;
    localparam int M_DATA_W        = SEQ_W + CNT_W + CNT_W;

    // Input opcodes
    localparam logic [OPC_W-1:0] OPC_MISS = 2'd0;
    localparam logic [OPC_W-1:0] OPC_RECV = 2'd1;
    localparam logic [OPC_W-1:0] OPC_TICK = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_FIRST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIES      = 2'd1;

    // Register reset values
    localparam logic [INTV_W-1:0]  RETRY_INTERVAL_RST = 16'd33;
    localparam logic [TRIES_W-1:0] MAX_TRIES_RST      = 4'd3;

    // One table slot
    typedef struct packed {
        logic               valid;
        logic               emit;       // retry word still to be sent
        logic [SEQ_W-1:0]   seq;
        logic [TRIES_W-1:0] tries;
        logic [TIME_W-1:0]  last_time;
    } entry_t;

    // What every cell does this cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE,
        CELL_SORT
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic              phase;      // odd-even sort phase
        logic [SEQ_W-1:0]  key;
        logic [TIME_W-1:0] now;
    } chain_cmd_t;

    // Compare results a cell shows to its upper neighbor
    typedef struct packed {
        logic gt;
        logic hit;
    } cell_flags_t;

endpackage

@@ rtl/core/nack_retry_table.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nack_retry_table
// Table of missing packet sequence numbers with retry timing, held as a
// sorted row of cells. Emits first requests, retries and table-full drops.
// ============================================================================
//
//  Channel   Direction  Handshake           Contents
//  s_        in         s_tvalid/s_tready   tdata: seq, now_ms; tuser: opcode
//  m_        out        m_tvalid/m_tready   tdata: seq_res, requested_total,
//                                           given_up_total; tuser: kind; tlast
//  cfg_      in         cfg_valid/cfg_ready index 0 retry_interval_ms,
//                                           index 1 max_tries
//
//  Miss and received words: accept, then a table step (EXEC) that compares
//  all cells at once and shifts the row; a result waits for a free output
//  register.
//  A tick scans the row (EVAL), then rotates out retry words (EMIT, held by
//  output stalls) when any are due, then runs the odd-even compaction (SORT)
//  when any entry was given up.
//  aresetn is synchronous; valid bits clear directly under reset, no clearing pass.
//  Configuration writes are always ready.
// ============================================================================
module nack_retry_table
    import nrt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [15:0] seq, [47:16] now_ms
    input  logic [OPC_W-1:0]      s_tuser,   // [1:0] opcode
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [15:0] seq_res, [47:16] requested_total,
                                             // [79:48] given_up_total
    output logic [KIND_W-1:0]     m_tuser,   // [1:0] kind
    output logic                  m_tlast,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STEP_W = $clog2(TABLE_DEPTH);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EVAL,
        ST_EMIT,
        ST_SORT
    } state_t;

    state_t              state_reg;
    logic [OPC_W-1:0]    op_reg;
    logic [SEQ_W-1:0]    key_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [RCNT_W-1:0]   rcnt_reg;
    logic [RCNT_W-1:0]   rcnt_next;
    logic [RCNT_W-1:0]   emit_cnt_reg;
    logic [RCNT_W-1:0]   emit_cnt_next;
    logic                gave_reg;
    logic                gave_next;
    logic [CNT_W-1:0]    req_cnt_reg;
    logic [CNT_W-1:0]    req_cnt_next;
    logic [CNT_W-1:0]    give_cnt_reg;
    logic [CNT_W-1:0]    give_cnt_next;
    logic [INTV_W-1:0]   interval_reg;
    logic [TRIES_W-1:0]  max_tries_reg;

    logic                m_tvalid_reg;
    logic [SEQ_W-1:0]    out_seq_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic                out_last_reg;
    logic [CNT_W-1:0]    out_req_reg;
    logic [CNT_W-1:0]    out_give_reg;

    chain_cmd_t          cmd;
    entry_t              wb;
    entry_t              head;
    logic                hit_any;
    logic                full;
    logic [TABLE_DEPTH-1:0] valid_vec;

    logic                s_acc;
    logic                out_free;
    logic                out_load;
    logic [SEQ_W-1:0]    out_seq;
    logic [KIND_W-1:0]   out_kind;
    logic                out_last;
    logic                exec_done;
    logic                advance;
    logic                step_last;
    logic [TIME_W-1:0]   elapsed;
    logic                due;

    // Table row
    nrt_chain #(
        .DEPTH (TABLE_DEPTH)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .wb        (wb),
        .head      (head),
        .hit_any   (hit_any),
        .full      (full),
        .valid_vec (valid_vec)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign step_last = (step_reg == STEP_LAST);
    assign elapsed   = now_reg - head.last_time;
    assign due       = (elapsed >= {{(TIME_W-INTV_W){1'b0}}, interval_reg});

    // Per-state table command, head write-back and result word
    always_comb begin
        cmd.op        = CELL_HOLD;
        cmd.phase     = step_reg[0];
        cmd.key       = key_reg;
        cmd.now       = now_reg;
        wb            = head;
        out_load      = 1'b0;
        out_seq       = key_reg;
        out_kind      = KIND_FIRST;
        out_last      = 1'b1;
        req_cnt_next  = req_cnt_reg;
        give_cnt_next = give_cnt_reg;
        rcnt_next     = rcnt_reg;
        emit_cnt_next = emit_cnt_reg;
        gave_next     = gave_reg;
        exec_done     = 1'b0;
        advance       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_EXEC: begin
                if (op_reg == OPC_MISS) begin
                    exec_done = hit_any || out_free;
                    if (!hit_any && out_free) begin
                        out_load = 1'b1;
                        if (full) begin
                            out_kind = KIND_FULL;
                        end else begin
                            cmd.op       = CELL_INSERT;
                            req_cnt_next = req_cnt_reg + CNT_W'(1);
                        end
                    end
                end else begin
                    exec_done = 1'b1;
                    if (hit_any) begin
                        cmd.op = CELL_DELETE;
                    end
                end
            end
            ST_EVAL: begin
                // judge the head entry, send it round to the tail
                cmd.op  = CELL_ROTATE;
                advance = 1'b1;
                if (head.valid && due) begin
                    if (head.tries >= max_tries_reg) begin
                        wb.valid      = 1'b0;
                        give_cnt_next = give_cnt_reg + CNT_W'(1);
                        gave_next     = 1'b1;
                    end else if (rcnt_reg < RCNT_W'(RESULT_CAP)) begin
                        wb.tries     = head.tries + TRIES_W'(1);
                        wb.last_time = now_reg;
                        wb.emit      = 1'b1;
                        req_cnt_next = req_cnt_reg + CNT_W'(1);
                        rcnt_next    = rcnt_reg + RCNT_W'(1);
                    end
                end
            end
            ST_EMIT: begin
                // marked entries leave as retry words in ascending order
                if (!head.emit || out_free) begin
                    cmd.op  = CELL_ROTATE;
                    advance = 1'b1;
                    wb.emit = 1'b0;
                    if (head.emit) begin
                        out_load      = 1'b1;
                        out_seq       = head.seq;
                        out_kind      = KIND_RETRY;
                        out_last      = (emit_cnt_reg + RCNT_W'(1)) == rcnt_reg;
                        emit_cnt_next = emit_cnt_reg + RCNT_W'(1);
                    end
                end
            end
            ST_SORT: begin
                cmd.op  = CELL_SORT;
                advance = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            rcnt_reg     <= '0;
            emit_cnt_reg <= '0;
            gave_reg     <= 1'b0;
            req_cnt_reg  <= '0;
            give_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            req_cnt_reg  <= req_cnt_next;
            give_cnt_reg <= give_cnt_next;

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                out_seq_reg  <= out_seq;
                out_kind_reg <= out_kind;
                out_last_reg <= out_last;
                out_req_reg  <= req_cnt_next;
                out_give_reg <= give_cnt_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (advance) begin
                step_reg <= step_last ? '0 : step_reg + STEP_W'(1);
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        op_reg  <= s_tuser;
                        key_reg <= s_tdata[SEQ_W-1:0];
                        now_reg <= s_tdata[S_DATA_W-1:SEQ_W];
                        if (s_tuser == OPC_MISS || s_tuser == OPC_RECV) begin
                            state_reg <= ST_EXEC;
                        end else if (s_tuser == OPC_TICK) begin
                            state_reg <= ST_EVAL;
                            step_reg  <= '0;
                            rcnt_reg  <= '0;
                            gave_reg  <= 1'b0;
                        end
                    end
                end
                ST_EXEC: begin
                    if (exec_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EVAL: begin
                    rcnt_reg <= rcnt_next;
                    gave_reg <= gave_next;
                    if (step_last) begin
                        emit_cnt_reg <= '0;
                        if (rcnt_next != '0) begin
                            state_reg <= ST_EMIT;
                        end else if (gave_next) begin
                            state_reg <= ST_SORT;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_EMIT: begin
                    emit_cnt_reg <= emit_cnt_next;
                    if (advance && step_last) begin
                        state_reg <= gave_reg ? ST_SORT : ST_IDLE;
                    end
                end
                ST_SORT: begin
                    if (step_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg  <= RETRY_INTERVAL_RST;
            max_tries_reg <= MAX_TRIES_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_RETRY_INTERVAL) begin
                interval_reg <= cfg_data;
            end else if (cfg_index == REG_MAX_TRIES) begin
                max_tries_reg <= cfg_data[TRIES_W-1:0];
            end
        end
    end

    // Result port
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_give_reg, out_req_reg, out_seq_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    a_idle_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |->
            ((valid_vec & (valid_vec + TABLE_DEPTH'(1))) == '0))
        else $error("table not packed while idle");

    a_load_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (state_reg == ST_EXEC || state_reg == ST_EMIT))
        else $error("result word loaded outside exec or emit");

    a_rcnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        rcnt_reg <= RCNT_W'(RESULT_CAP))
        else $error("retry count above cap");

    a_first_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && op_reg == OPC_MISS && !hit_any && !full && out_free)
            |=> (req_cnt_reg == $past(req_cnt_reg) + CNT_W'(1)))
        else $error("first request not counted");

    a_emit_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && advance && step_last) |=> (emit_cnt_reg == rcnt_reg))
        else $error("retry words lost in emit rotation");

endmodule

@@ rtl/core/nrt_cell.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nrt_cell
// One slot of the sorted table. Compares its sequence with the broadcast key
// and shifts, inserts, rotates or swaps with its neighbors as commanded.
// ============================================================================
module nrt_cell
    import nrt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  chain_cmd_t  cmd,
    input  logic        odd_pos,
    input  entry_t      prev_e,
    input  cell_flags_t prev_flags,
    input  entry_t      next_e,
    output entry_t      e,
    output cell_flags_t flags
);

    entry_t e_reg;
    entry_t e_next;
    entry_t fresh;

    // Key compare against the broadcast sequence
    assign flags.gt  = e_reg.valid && (e_reg.seq > cmd.key);
    assign flags.hit = e_reg.valid && (e_reg.seq == cmd.key);
    assign e         = e_reg;

    // Entry created by a miss
    always_comb begin
        fresh           = '0;
        fresh.valid     = 1'b1;
        fresh.seq       = cmd.key;
        fresh.tries     = TRIES_W'(1);
        fresh.last_time = cmd.now;
    end

    // Next slot contents
    always_comb begin
        e_next = e_reg;
        unique case (cmd.op)
            CELL_HOLD: begin
            end
            CELL_INSERT: begin
                // larger entries move up one; first free or larger slot takes the key
                if (prev_flags.gt) begin
                    e_next = prev_e;
                end else if ((!e_reg.valid || flags.gt) && prev_e.valid) begin
                    e_next = fresh;
                end
            end
            CELL_DELETE: begin
                if (flags.gt || flags.hit) begin
                    e_next = next_e;
                end
            end
            CELL_ROTATE: begin
                e_next = next_e;
            end
            CELL_SORT: begin
                // odd-even transposition: empty slots bubble upward
                if (odd_pos == cmd.phase) begin
                    if (!e_reg.valid && next_e.valid) begin
                        e_next = next_e;
                    end
                end else if (!prev_e.valid && e_reg.valid) begin
                    e_next = prev_e;
                end
            end
            default: begin
            end
        endcase
    end

    // Slot register; only the control bits take reset
    always_ff @(posedge aclk) begin
        e_reg.seq       <= e_next.seq;
        e_reg.tries     <= e_next.tries;
        e_reg.last_time <= e_next.last_time;
        if (!aresetn) begin
            e_reg.valid <= 1'b0;
            e_reg.emit  <= 1'b0;
        end else begin
            e_reg.valid <= e_next.valid;
            e_reg.emit  <= e_next.emit;
        end
    end

endmodule

@@ rtl/core/nrt_chain.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nrt_chain
// Row of table cells kept in ascending sequence order, valid slots packed at
// the low end. Cell 0 is the head; rotation feeds the write-back to the tail.
// ============================================================================
module nrt_chain
    import nrt_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  chain_cmd_t       cmd,
    input  entry_t           wb,
    output entry_t           head,
    output logic             hit_any,
    output logic             full,
    output logic [DEPTH-1:0] valid_vec
);

    localparam entry_t ENTRY_NONE = '0;
    localparam entry_t ENTRY_EDGE = '{valid: 1'b1, default: '0};

    entry_t      ent   [DEPTH];
    cell_flags_t flg   [DEPTH];
    entry_t      prv   [DEPTH];
    entry_t      nxt   [DEPTH];
    cell_flags_t pflg  [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            // lower edge looks like a small valid entry
            if (g == 0) begin : g_low
                assign prv[g]  = ENTRY_EDGE;
                assign pflg[g] = '0;
            end else begin : g_mid_low
                assign prv[g]  = ent[g-1];
                assign pflg[g] = flg[g-1];
            end
            // upper edge takes the write-back during rotation, else empty
            if (g == DEPTH - 1) begin : g_high
                assign nxt[g] = (cmd.op == CELL_ROTATE) ? wb : ENTRY_NONE;
            end else begin : g_mid_high
                assign nxt[g] = ent[g+1];
            end

            nrt_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .odd_pos    (1'(g % 2)),
                .prev_e     (prv[g]),
                .prev_flags (pflg[g]),
                .next_e     (nxt[g]),
                .e          (ent[g]),
                .flags      (flg[g])
            );

            assign valid_vec[g] = ent[g].valid;
        end
    endgenerate

    // Match anywhere in the row
    always_comb begin
        hit_any = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_any = hit_any | flg[i].hit;
        end
    end

    assign head = ent[0];
    assign full = ent[DEPTH-1].valid;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the NACK retry table. A scoreboard class keeps its
// own copy of the table and counters, predicts the request words for every
// accepted input word and checks each result word in order. Stimulus is a
// short directed sequence, then random phases under several register
// settings, with bursty input, random output stalls and one long hold-off.
// ============================================================================
module testbench;
    import nrt_pkg::*;

    localparam int TABLE_SLOTS    = TABLE_DEPTH_DEF;
    localparam int POOL_SIZE      = 48;     // more seqs than slots, so the table fills
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 128;    // longest tick: scan + rotate + compaction
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [OPC_W-1:0] OPC_UNUSED = 2'd3;

    // One result word, in the order it is rebuilt from the output ports
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [KIND_W-1:0] kind;
        logic              last;
        logic [CNT_W-1:0]  req_total;
        logic [CNT_W-1:0]  gu_total;
    } request_word_t;

    // ------------------------------------------------------------------------
    // Retry table predictor and result checker
    // ------------------------------------------------------------------------
    class retry_request_scoreboard;
        logic               slot_valid [TABLE_SLOTS];
        logic [SEQ_W-1:0]   slot_seq   [TABLE_SLOTS];
        logic [TRIES_W-1:0] slot_tries [TABLE_SLOTS];
        logic [TIME_W-1:0]  slot_time  [TABLE_SLOTS];
        logic [CNT_W-1:0]   requests_issued;
        logic [CNT_W-1:0]   entries_abandoned;
        logic [INTV_W-1:0]  retry_interval;
        logic [TRIES_W-1:0] try_limit;
        request_word_t      expected_requests[$];
        int mismatches;
        int misses_seen, receipts_seen, ticks_seen, unused_seen;
        int first_words, retry_words, full_words;

        function new();
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            requests_issued   = '0;
            entries_abandoned = '0;
            retry_interval    = RETRY_INTERVAL_RST;
            try_limit         = MAX_TRIES_RST;
            mismatches        = 0;
            misses_seen = 0; receipts_seen = 0; ticks_seen = 0; unused_seen = 0;
            first_words = 0; retry_words = 0; full_words = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RETRY_INTERVAL: retry_interval = data[INTV_W-1:0];
                REG_MAX_TRIES:      try_limit      = data[TRIES_W-1:0];
                default: ;
            endcase
        endfunction

        function int find_seq(logic [SEQ_W-1:0] seq);
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (slot_valid[i] && slot_seq[i] == seq) return i;
            return -1;
        endfunction

        function int words_outstanding();
            return expected_requests.size();
        endfunction

        // Work out the words caused by one accepted input word
        function void note_input(logic [OPC_W-1:0] op, logic [SEQ_W-1:0] seq,
                                 logic [TIME_W-1:0] stamp);
            request_word_t     burst[$];
            request_word_t     w;
            logic [TIME_W-1:0] elapsed;
            int slot;
            int prev;
            int best;
            w = '0;
            case (op)
                OPC_MISS: begin
                    misses_seen++;
                    if (find_seq(seq) < 0) begin
                        slot = -1;
                        for (int i = 0; i < TABLE_SLOTS; i++)
                            if (!slot_valid[i] && slot < 0) slot = i;
                        w.seq = seq;
                        if (slot < 0) begin
                            w.kind = KIND_FULL;
                            full_words++;
                        end else begin
                            slot_valid[slot] = 1'b1;
                            slot_seq[slot]   = seq;
                            slot_tries[slot] = 4'd1;
                            slot_time[slot]  = stamp;
                            requests_issued++;
                            w.kind = KIND_FIRST;
                            first_words++;
                        end
                        burst.insert(burst.size(), w);
                    end
                end
                OPC_RECV: begin
                    receipts_seen++;
                    slot = find_seq(seq);
                    if (slot >= 0) slot_valid[slot] = 1'b0;
                end
                OPC_TICK: begin
                    ticks_seen++;
                    prev = -1;
                    // visit held entries in ascending seq order
                    while (1) begin
                        best = -1;
                        for (int i = 0; i < TABLE_SLOTS; i++)
                            if (slot_valid[i] && int'(slot_seq[i]) > prev &&
                                (best < 0 || slot_seq[i] < slot_seq[best]))
                                best = i;
                        if (best < 0) break;
                        prev    = int'(slot_seq[best]);
                        elapsed = stamp - slot_time[best];
                        if (elapsed < {16'd0, retry_interval}) continue;
                        if (slot_tries[best] >= try_limit) begin
                            entries_abandoned++;
                            slot_valid[best] = 1'b0;
                            continue;
                        end
                        // past the cap, retries wait for a later tick
                        if (burst.size() >= RESULT_CAP) continue;
                        slot_tries[best] = slot_tries[best] + 4'd1;
                        slot_time[best]  = stamp;
                        requests_issued++;
                        w.seq  = slot_seq[best];
                        w.kind = KIND_RETRY;
                        retry_words++;
                        burst.insert(burst.size(), w);
                    end
                end
                default: unused_seen++;
            endcase
            // totals reflect the whole input; last marks the final word
            foreach (burst[k]) begin
                burst[k].req_total = requests_issued;
                burst[k].gu_total  = entries_abandoned;
                burst[k].last      = (k == burst.size() - 1);
                expected_requests.insert(expected_requests.size(), burst[k]);
            end
        endfunction

        task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
            $display("%0t ns MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
            mismatches++;
        endtask

        task check_word(request_word_t got);
            request_word_t want;
            if (expected_requests.size() == 0) begin
                report_mismatch("result word with nothing expected, seq_res", '0, got.seq);
                return;
            end
            want = expected_requests.pop_front();
            if (got.seq !== want.seq)             report_mismatch("seq_res", want.seq, got.seq);
            if (got.kind !== want.kind)           report_mismatch("kind", want.kind, got.kind);
            if (got.last !== want.last)           report_mismatch("tlast", want.last, got.last);
            if (got.req_total !== want.req_total)
                report_mismatch("requested_total", want.req_total, got.req_total);
            if (got.gu_total !== want.gu_total)
                report_mismatch("given_up_total", want.gu_total, got.gu_total);
        endtask

        task check_drained();
            if (expected_requests.size() != 0)
                report_mismatch("words never delivered, count", '0, expected_requests.size());
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and signals
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;   // [15:0] seq, [47:16] now_ms
    logic [OPC_W-1:0]      s_tuser   = '0;   // [1:0] opcode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;          // [15:0] seq_res, [47:16] requested_total,
                                             // [79:48] given_up_total
    logic [KIND_W-1:0]     m_tuser;          // [1:0] kind
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    retry_request_scoreboard sb = new();

    logic [TIME_W-1:0] clock_ms;
    bit                hold_off_req = 1'b0;
    int                settings_used = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    nack_retry_table #(.TABLE_DEPTH(TABLE_SLOTS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // ------------------------------------------------------------------------
    // Handshake monitor: register writes, input words, result words
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata[SEQ_W-1:0], s_tdata[S_DATA_W-1:SEQ_W]);
            if (m_tvalid && m_tready)
                sb.check_word({m_tdata[15:0], m_tuser, m_tlast, m_tdata[47:16],
                               m_tdata[79:48]});
        end
    end

    // Watchdog: ends the run when no handshake happens for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("nack_retry_table test failed");
        $finish;
    end

    // Receiver: stall patterns in segments, plus one long hold-off on request
    initial begin
        int seg_len;
        int seg_mode;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            seg_len  = $urandom_range(8, 64);
            seg_mode = $urandom_range(0, 3);
            for (int c = 0; c < seg_len; c++) begin
                if (hold_off_req) begin
                    hold_off_req = 1'b0;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                case (seg_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= c[0];
                endcase
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    // Leaves s_tvalid high; the caller lowers it when a gap starts
    task automatic send_word(input logic [OPC_W-1:0] op, input logic [SEQ_W-1:0] seq,
                             input logic [TIME_W-1:0] stamp);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {stamp, seq};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Wait for every expected word, then let a tick with no result finish
    task automatic wait_for_idle();
        do @(posedge aclk); while (sb.words_outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register setting followed by random input words
    task automatic run_phase(input logic [INTV_W-1:0] interval, input logic [TRIES_W-1:0] tries,
                             input int n_items, input int fill_first);
        logic [SEQ_W-1:0] seq_pool [POOL_SIZE];
        logic [OPC_W-1:0] op;
        logic [SEQ_W-1:0] seq;
        int unsigned      step_max;
        int               burst_left;
        int               pick;
        wait_for_idle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_RETRY_INTERVAL;
        cfg_data  <= interval;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_MAX_TRIES;
        cfg_data  <= {12'($urandom()), tries};
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_used++;

        foreach (seq_pool[k]) seq_pool[k] = 16'($urandom());
        step_max   = (interval == 0) ? 8 : 2 * int'(interval);
        burst_left = $urandom_range(1, 12);
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (i < fill_first || pick < 45) op = OPC_MISS;
            else if (pick < 70)              op = OPC_RECV;
            else if (pick < 95)              op = OPC_TICK;
            else                             op = OPC_UNUSED;
            if (i < fill_first)                seq = seq_pool[i % POOL_SIZE];
            else if ($urandom_range(0, 7) == 0) seq = 16'($urandom());
            else                               seq = seq_pool[$urandom_range(0, POOL_SIZE - 1)];
            // mostly forward steps; now and then a jump anywhere, backward included
            if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
            else                            clock_ms = clock_ms + $urandom_range(0, step_max);
            send_word(op, seq, clock_ms);
            burst_left--;
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [TIME_W-1:0] t0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings (interval 33, three tries), time near the wrap
        t0 = 32'hFFFF_FFE0;
        send_word(OPC_MISS,   16'h0000, t0);
        send_word(OPC_MISS,   16'hFFFF, t0);
        send_word(OPC_MISS,   16'h0000, t0 + 1);         // already held
        send_word(OPC_RECV,   16'h1234, t0 + 2);         // not held
        send_word(OPC_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);  // ignored opcode
        send_word(OPC_TICK,   16'h0000, 32'hFFFF_FFFF);  // nothing due yet
        send_word(OPC_TICK,   16'h0000, t0 + 33);        // both due across the wrap
        send_word(OPC_MISS,   16'h8000, t0 + 34);
        send_word(OPC_TICK,   16'h0000, t0 + 70);        // three retries
        send_word(OPC_TICK,   16'h0000, t0 + 112);       // two give-ups, one retry
        send_word(OPC_RECV,   16'h8000, t0 + 113);
        send_word(OPC_TICK,   16'h0000, 32'h0000_0200);  // empty table, silent
        send_word(OPC_MISS,   16'h5555, 32'h0000_0201);
        send_word(OPC_MISS,   16'hAAAA, 32'h0000_0202);
        send_word(OPC_RECV,   16'hAAAA, 32'h0000_0203);
        send_word(OPC_TICK,   16'h0000, 32'h0000_0000);  // time went backward: due
        send_word(OPC_MISS,   16'h7FFF, 32'h8000_0000);
        s_tvalid <= 1'b0;
        clock_ms = 32'h8000_0000;

        // Random phases; the first fills the table under a long output hold-off
        wait_for_idle();
        hold_off_req = 1'b1;
        run_phase(16'd1, 4'd15, 70, 40);
        run_phase(16'hFFFF, 4'd1, 55, 0);
        run_phase(16'd0, 4'd4, 55, 0);                   // every entry due each tick
        run_phase(16'($urandom_range(2, 60)), 4'd0, 55, 0);   // due entries given up
        run_phase(16'($urandom_range(1, 200)), 4'($urandom_range(1, 15)), 70, 20);
        run_phase(16'($urandom_range(1, 65535)), 4'($urandom_range(1, 15)), 50, 0);
        wait_for_idle();

        sb.check_drained();
        $display("Covered %0d misses, %0d receipts, %0d ticks, %0d ignored words, %0d settings.",
                 sb.misses_seen, sb.receipts_seen, sb.ticks_seen, sb.unused_seen,
                 settings_used);
        $display("Checked %0d first requests, %0d retries, %0d table-full drops; %0d give-ups.",
                 sb.first_words, sb.retry_words, sb.full_words, sb.entries_abandoned);
        if (sb.mismatches == 0) begin
            $display("nack_retry_table test passed");
        end else begin
            $display("nack_retry_table test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/nrt_pkg.sv
rtl/core/nrt_cell.sv
rtl/core/nrt_chain.sv
rtl/core/nack_retry_table.sv
dv/testbench.sv
